FILE: rtl/gli_pkg.sv
// Shared types and constants for the GIF LZW image decoder.
// No dependencies; the decoder top level and the checker import this package.
package gli_pkg;

	typedef enum logic [7:0] {
		REG_MIN_CODE_SIZE = 8'd0,
		REG_LINE_WIDTH    = 8'd1,
		REG_IMAGE_HEIGHT  = 8'd2,
		REG_INTERLACED    = 8'd3
	} reg_index_t;

	localparam logic [3:0]  MIN_SIZE_RESET = 4'd8;
	localparam logic [15:0] LINE_RESET     = 16'd1;
	localparam logic [15:0] HEIGHT_RESET   = 16'd1;
	localparam logic [6:0]  MAX_RESULTS    = 7'd64;
	localparam logic [15:0] MARK_POS       = 16'hFFFF;

	typedef struct packed {
		logic [7:0] data_byte;
	} byte_beat_t;

	typedef struct packed {
		logic [7:0]  pixel_index;
		logic [15:0] column;
		logic [15:0] row;
		logic        last_of_run;
		logic        image_done;
		logic        bad_code;
	} pixel_beat_t;

	typedef struct packed {
		logic [7:0]  index;
		logic [15:0] wdata;
	} cfg_beat_t;

endpackage

FILE: rtl/gli_stream_if.sv
// Valid/ready channel carrying one payload beat of a given type.
// Depends on nothing; payload types come from gli_pkg at the instance.
interface gli_stream_if #(parameter type T = logic [7:0]);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/gli_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/gif_lzw_image_decoder.sv
// GIF LZW image decoder top level: unpacks codes from the sub-block byte stream and
// expands them into positioned pixels. Uses gli_pkg, gli_stream_if and gli_ram.
//
// One input beat is one stream byte. A byte is taken in the idle state; then the codes it
// completes are unpacked, each code is walked back through the prefix/suffix tables onto
// the reversal stack, and the stack is popped to emit pixels. Table and stack reads are
// registered, so every table step and every pixel waits for its read data. One beat
// produces at most 64 pixels; when more are stacked the last pixel carries last_of_run low
// and the next byte presented is not consumed, only used to continue draining, so it must
// be sent again. A configuration write restarts the image if the decoder is idle when the
// restart takes effect, and holds input off while it is applied; the tables are never
// cleared.
module gif_lzw_image_decoder import gli_pkg::*; #(
	parameter int MAX_CODE_BITS = 12,
	parameter int STACK_DEPTH = 4096
) (
	input  logic         clk,
	input  logic         arst_n,
	gli_stream_if.sink   cfg,
	gli_stream_if.sink   byte_in,
	gli_stream_if.source pixel_out
);
	localparam int TW = MAX_CODE_BITS;
	localparam int NSW = TW + 1;
	localparam int TDEPTH = 1 << TW;
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam int SMAX = (9 < TW - 1) ? 9 : TW - 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOOP, ST_POP, ST_WALK, ST_WALK_DATA, ST_END
	} state_t;

	state_t state_q, state_d;
	logic [3:0] min_size_q;
	logic [15:0] line_width_q, height_q;
	logic interlaced_q, restart_q;

	logic [3:0] code_width_q, code_width_d;
	logic [NSW-1:0] next_slot_q, next_slot_d, width_limit_q, width_limit_d;
	logic [TW-1:0] prev_code_q, prev_code_d, walk_code_q, walk_code_d, cur_code_q, cur_code_d;
	logic [7:0] first_char_q, first_char_d, block_left_q, block_left_d;
	logic [23:0] acc_q, acc_d;
	logic [4:0] bits_q, bits_d;
	logic [15:0] col_q, col_d, rows_q, rows_d;
	logic finished_q, finished_d, after_clear_q, after_clear_d, bad_q, bad_d;
	logic [SCW-1:0] stack_cnt_q, stack_cnt_d;
	logic [6:0] run_cnt_q, run_cnt_d;
	logic hold_v_q, hold_v_d, out_v_q, out_v_d;
	pixel_beat_t hold_q, hold_d, out_q, out_d;

	logic tab_we, tab_re, stk_we, stk_re;
	logic [7:0] stk_wdata, stk_rdata, suf_rdata;
	logic [TW-1:0] pre_rdata;
	logic push_req, emit_req, emit_ok, pending, end_cond, grow_slot;
	logic [7:0] push_val;
	pixel_beat_t emit_beat, marker;

	logic [3:0] eff_size;
	logic [TW-1:0] clr_code, end_code, width_mask, code_now, first_code;
	logic [NSW-1:0] new_code, slot_after;
	logic [16:0] h_ext, r_ext, thr1, thr2, thr3, col_inc;
	logic [15:0] mapped_row;

	gli_ram #(.WIDTH(TW), .DEPTH(TDEPTH)) u_prefix (
		.clk(clk), .we(tab_we), .waddr(next_slot_q[TW-1:0]), .wdata(prev_code_q),
		.re(tab_re), .raddr(walk_code_q), .rdata(pre_rdata)
	);

	gli_ram #(.WIDTH(8), .DEPTH(TDEPTH)) u_suffix (
		.clk(clk), .we(tab_we), .waddr(next_slot_q[TW-1:0]), .wdata(walk_code_q[7:0]),
		.re(tab_re), .raddr(walk_code_q), .rdata(suf_rdata)
	);

	gli_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .waddr(stack_cnt_q[SAW-1:0]), .wdata(stk_wdata),
		.re(stk_re), .raddr(SAW'(stack_cnt_q - SCW'(1))), .rdata(stk_rdata)
	);

	assign cfg.ready = 1'b1;
	assign byte_in.ready = (state_q == ST_IDLE) && !restart_q;
	assign pixel_out.valid = out_v_q;
	assign pixel_out.data = out_q;

	always_comb begin
		if (min_size_q < 4'd2) begin
			eff_size = 4'd2;
		end else if (min_size_q > 4'(SMAX)) begin
			eff_size = 4'(SMAX);
		end else begin
			eff_size = min_size_q;
		end
	end

	assign clr_code = TW'(1) << eff_size;
	assign end_code = clr_code + TW'(1);
	assign new_code = {1'b0, clr_code} + NSW'(2);
	assign width_mask = ~({TW{1'b1}} << code_width_q);
	assign code_now = acc_q[TW-1:0] & width_mask;
	assign first_code = ({1'b0, code_now} >= next_slot_q) ? '0 : code_now;

	assign h_ext = {1'b0, height_q};
	assign r_ext = {1'b0, rows_q};
	assign thr1 = (h_ext + 17'd7) >> 3;
	assign thr2 = thr1 + ((h_ext + 17'd3) >> 3);
	assign thr3 = thr2 + ((h_ext + 17'd1) >> 2);
	assign col_inc = {1'b0, col_q} + 17'd1;

	always_comb begin
		if (!interlaced_q) begin
			mapped_row = rows_q;
		end else if (r_ext < thr1) begin
			mapped_row = 16'(r_ext << 3);
		end else if (r_ext < thr2) begin
			mapped_row = 16'(((r_ext - thr1) << 3) + 17'd4);
		end else if (r_ext < thr3) begin
			mapped_row = 16'(((r_ext - thr2) << 2) + 17'd2);
		end else begin
			mapped_row = 16'(((r_ext - thr3) << 1) + 17'd1);
		end
	end

	assign marker = '{pixel_index: 8'd0, column: MARK_POS, row: MARK_POS,
		last_of_run: 1'b0, image_done: 1'b1, bad_code: bad_q};
	assign emit_ok = !hold_v_q || !out_v_q || pixel_out.ready;
	assign pending = (stack_cnt_q != '0) || (bits_q >= {1'b0, code_width_q});
	assign end_cond = finished_q || ((stack_cnt_q == '0) && (bits_q < {1'b0, code_width_q}));
	assign grow_slot = next_slot_q < width_limit_q;
	assign slot_after = grow_slot ? next_slot_q + NSW'(1) : next_slot_q;

	always_comb begin
		state_d = state_q;
		code_width_d = code_width_q;
		next_slot_d = next_slot_q;
		width_limit_d = width_limit_q;
		prev_code_d = prev_code_q;
		walk_code_d = walk_code_q;
		cur_code_d = cur_code_q;
		first_char_d = first_char_q;
		block_left_d = block_left_q;
		acc_d = acc_q;
		bits_d = bits_q;
		col_d = col_q;
		rows_d = rows_q;
		finished_d = finished_q;
		after_clear_d = after_clear_q;
		bad_d = bad_q;
		stack_cnt_d = stack_cnt_q;
		run_cnt_d = run_cnt_q;
		hold_v_d = hold_v_q;
		hold_d = hold_q;
		out_v_d = out_v_q;
		out_d = out_q;
		tab_we = 1'b0;
		tab_re = 1'b0;
		stk_re = 1'b0;
		push_req = 1'b0;
		push_val = '0;
		emit_req = 1'b0;
		emit_beat = marker;

		if (out_v_q && pixel_out.ready) begin
			out_v_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (restart_q) begin
					code_width_d = eff_size + 4'd1;
					width_limit_d = NSW'(1) << (eff_size + 4'd1);
					next_slot_d = new_code;
					prev_code_d = '0;
					first_char_d = '0;
					acc_d = '0;
					bits_d = '0;
					block_left_d = '0;
					col_d = '0;
					rows_d = '0;
					finished_d = 1'b0;
					after_clear_d = 1'b1;
					bad_d = 1'b0;
					stack_cnt_d = '0;
				end else if (byte_in.valid && !finished_q) begin
					run_cnt_d = '0;
					state_d = ST_LOOP;
					if (!pending) begin
						if (block_left_q == 8'd0) begin
							if (byte_in.data.data_byte == 8'd0) begin
								emit_req = 1'b1;
								finished_d = 1'b1;
								stack_cnt_d = '0;
							end else begin
								block_left_d = byte_in.data.data_byte;
							end
						end else begin
							acc_d = acc_q | (24'(byte_in.data.data_byte) << bits_q);
							bits_d = bits_q + 5'd8;
							block_left_d = block_left_q - 8'd1;
						end
					end
				end
			end
			ST_LOOP: begin
				if ((stack_cnt_q != '0) && (run_cnt_q < MAX_RESULTS) && !finished_q) begin
					stk_re = 1'b1;
					stack_cnt_d = stack_cnt_q - SCW'(1);
					state_d = ST_POP;
				end else if (finished_q || (stack_cnt_q != '0) || (run_cnt_q >= MAX_RESULTS)
						|| (bits_q < {1'b0, code_width_q})) begin
					state_d = ST_END;
				end else if (!((code_now == end_code) && !emit_ok)) begin
					acc_d = acc_q >> code_width_q;
					bits_d = bits_q - {1'b0, code_width_q};
					if (code_now == clr_code) begin
						code_width_d = eff_size + 4'd1;
						width_limit_d = NSW'(1) << (eff_size + 4'd1);
						next_slot_d = new_code;
						after_clear_d = 1'b1;
					end else if (code_now == end_code) begin
						emit_req = 1'b1;
						finished_d = 1'b1;
						stack_cnt_d = '0;
					end else if (after_clear_q) begin
						if ({1'b0, code_now} >= next_slot_q) begin
							bad_d = 1'b1;
						end
						push_req = 1'b1;
						push_val = first_code[7:0];
						prev_code_d = first_code;
						first_char_d = first_code[7:0];
						after_clear_d = 1'b0;
					end else begin
						cur_code_d = code_now;
						walk_code_d = code_now;
						if ({1'b0, code_now} >= next_slot_q) begin
							if ({1'b0, code_now} > next_slot_q) begin
								bad_d = 1'b1;
							end
							push_req = 1'b1;
							push_val = first_char_q;
							walk_code_d = prev_code_q;
						end
						state_d = ST_WALK;
					end
				end
			end
			ST_POP: begin
				if (emit_ok) begin
					emit_req = 1'b1;
					state_d = ST_LOOP;
					if (rows_q >= height_q) begin
						finished_d = 1'b1;
						stack_cnt_d = '0;
					end else begin
						emit_beat = '{pixel_index: stk_rdata, column: col_q, row: mapped_row,
							last_of_run: 1'b0, image_done: 1'b0, bad_code: bad_q};
						if (col_inc >= {1'b0, line_width_q}) begin
							col_d = '0;
							rows_d = rows_q + 16'd1;
						end else begin
							col_d = col_inc[15:0];
						end
					end
				end
			end
			ST_WALK: begin
				if (({1'b0, walk_code_q} >= new_code) && (stack_cnt_q < SCW'(STACK_DEPTH))) begin
					tab_re = 1'b1;
					state_d = ST_WALK_DATA;
				end else begin
					push_req = 1'b1;
					push_val = walk_code_q[7:0];
					first_char_d = walk_code_q[7:0];
					tab_we = grow_slot;
					next_slot_d = slot_after;
					prev_code_d = cur_code_q;
					if ((slot_after >= width_limit_q) && (code_width_q < 4'(TW))) begin
						code_width_d = code_width_q + 4'd1;
						width_limit_d = width_limit_q << 1;
					end
					state_d = ST_LOOP;
				end
			end
			ST_WALK_DATA: begin
				push_req = 1'b1;
				push_val = suf_rdata;
				walk_code_d = pre_rdata;
				state_d = ST_WALK;
			end
			ST_END: begin
				if (!hold_v_q) begin
					state_d = ST_IDLE;
				end else if (!out_v_q || pixel_out.ready) begin
					out_d = hold_q;
					out_d.last_of_run = end_cond;
					out_v_d = 1'b1;
					hold_v_d = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		stk_we = push_req && (stack_cnt_q < SCW'(STACK_DEPTH));
		stk_wdata = push_val;
		if (stk_we) begin
			stack_cnt_d = stack_cnt_q + SCW'(1);
		end

		if (emit_req) begin
			if (hold_v_q) begin
				out_d = hold_q;
				out_v_d = 1'b1;
			end
			hold_d = emit_beat;
			hold_v_d = 1'b1;
			run_cnt_d = run_cnt_q + 7'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			min_size_q <= MIN_SIZE_RESET;
			line_width_q <= LINE_RESET;
			height_q <= HEIGHT_RESET;
			interlaced_q <= 1'b0;
			restart_q <= 1'b1;
			code_width_q <= '0;
			next_slot_q <= '0;
			width_limit_q <= '0;
			prev_code_q <= '0;
			first_char_q <= '0;
			block_left_q <= '0;
			acc_q <= '0;
			bits_q <= '0;
			col_q <= '0;
			rows_q <= '0;
			finished_q <= 1'b0;
			after_clear_q <= 1'b1;
			bad_q <= 1'b0;
			stack_cnt_q <= '0;
			run_cnt_q <= '0;
			hold_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			code_width_q <= code_width_d;
			next_slot_q <= next_slot_d;
			width_limit_q <= width_limit_d;
			prev_code_q <= prev_code_d;
			first_char_q <= first_char_d;
			block_left_q <= block_left_d;
			acc_q <= acc_d;
			bits_q <= bits_d;
			col_q <= col_d;
			rows_q <= rows_d;
			finished_q <= finished_d;
			after_clear_q <= after_clear_d;
			bad_q <= bad_d;
			stack_cnt_q <= stack_cnt_d;
			run_cnt_q <= run_cnt_d;
			hold_v_q <= hold_v_d;
			out_v_q <= out_v_d;
			restart_q <= 1'b0;
			if (cfg.valid) begin
				unique case (cfg.data.index)
					REG_MIN_CODE_SIZE: begin
						min_size_q <= cfg.data.wdata[3:0];
						restart_q <= 1'b1;
					end
					REG_LINE_WIDTH: begin
						line_width_q <= cfg.data.wdata;
						restart_q <= 1'b1;
					end
					REG_IMAGE_HEIGHT: begin
						height_q <= cfg.data.wdata;
						restart_q <= 1'b1;
					end
					REG_INTERLACED: begin
						interlaced_q <= cfg.data.wdata[0];
						restart_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		walk_code_q <= walk_code_d;
		cur_code_q <= cur_code_d;
		hold_q <= hold_d;
		out_q <= out_d;
	end
endmodule

FILE: rtl/gli_checker.sv
// Port-level checks for the GIF LZW image decoder, bound to the top level.
// Depends on gli_pkg and the ports of gif_lzw_image_decoder.
module gli_checker import gli_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input pixel_beat_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("pixel beat changed while stalled");

	a_done_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.image_done |-> out_data.last_of_run
			&& out_data.column == MARK_POS && out_data.row == MARK_POS)
		else $error("done marker beat malformed");

	a_done_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.image_done |=> !out_valid)
		else $error("pixel beat followed the done marker");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("input taken during restart after a register write");
endmodule

bind gif_lzw_image_decoder gli_checker u_gli_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cfg_valid(cfg.valid),
	.cfg_ready(cfg.ready),
	.in_ready(byte_in.ready),
	.out_valid(pixel_out.valid),
	.out_ready(pixel_out.ready),
	.out_data(pixel_out.data)
);
